/* rtl/l2s_pkg.sv */
// Shared constants for the linear index to subscripts converter.
package l2s_pkg;

    localparam int SIZE_WIDTH    = 32;
    localparam int SUB_WIDTH     = 32;
    localparam int IN_WIDTH      = 32;
    localparam int NUM_SIZE_REGS = 6;
    localparam int CFG_IDX_WIDTH = 3;

    typedef logic [CFG_IDX_WIDTH-1:0] cfg_idx_t;
    typedef logic [SIZE_WIDTH-1:0]    size_t;

    localparam cfg_idx_t REG_SIZE_DIM0 = cfg_idx_t'(0);
    localparam cfg_idx_t REG_SIZE_LAST = cfg_idx_t'(NUM_SIZE_REGS - 1);

    typedef struct packed {
        logic en;
        logic valid;
    } l2s_ctrl_t;

endpackage

/* rtl/linear_index_to_subscripts.sv */
// Column-major linear index to per-dimension subscripts, bit-serial pipelined division.
//
//  channel  | handshake              | payload
//  request  | s_valid / s_ready      | s_linear_index
//  result   | m_valid / m_ready      | m_sub0..m_sub5, m_out_of_range
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One request per cycle while the result is not stalled; one pipeline stage per
// quotient bit of each dimension's divider, plus the output register.
// Reset clears all stage valid bits and sets every size register to 1.
// A stalled result holds the whole pipeline; nothing is dropped or repeated.
module linear_index_to_subscripts import l2s_pkg::*; #(
    parameter int MAX_DIMS    = 6,
    parameter int INDEX_WIDTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [IN_WIDTH-1:0]  s_linear_index,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [SUB_WIDTH-1:0] m_sub0,
    output logic [SUB_WIDTH-1:0] m_sub1,
    output logic [SUB_WIDTH-1:0] m_sub2,
    output logic [SUB_WIDTH-1:0] m_sub3,
    output logic [SUB_WIDTH-1:0] m_sub4,
    output logic [SUB_WIDTH-1:0] m_sub5,
    output logic                 m_out_of_range,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  cfg_idx_t             cfg_index,
    input  size_t                cfg_data
);

    localparam int QW   = (INDEX_WIDTH < IN_WIDTH) ? INDEX_WIDTH : IN_WIDTH;
    localparam int NSTG = MAX_DIMS * QW;

    size_t               size_reg [NUM_SIZE_REGS];
    size_t               divisor  [MAX_DIMS];
    logic                zero_any;
    logic                en;

    logic                stg_valid [NSTG];
    logic [QW-1:0]       stg_a     [NSTG];
    logic [QW-1:0]       stg_r     [NSTG];
    logic [QW-1:0]       sub_reg   [NSTG][MAX_DIMS];
    logic [QW-1:0]       sub_src   [NSTG][MAX_DIMS];

    logic                out_valid_reg;
    logic [SUB_WIDTH-1:0] out_sub_reg [NUM_SIZE_REGS];
    logic [SUB_WIDTH-1:0] out_sub_next [NUM_SIZE_REGS];
    logic                out_oor_reg;
    logic                out_oor_next;

    assign cfg_ready = 1'b1;
    assign en        = !out_valid_reg || m_ready;
    assign s_ready   = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SIZE_REGS; i++) begin
                size_reg[i] <= size_t'(1);
            end
        end else if (cfg_valid && cfg_ready && cfg_index <= REG_SIZE_LAST) begin
            size_reg[cfg_index] <= cfg_data;
        end
    end

    always_comb begin
        zero_any = 1'b0;
        for (int d = 0; d < MAX_DIMS; d++) begin
            divisor[d] = (size_reg[d] == '0) ? size_t'(1) : size_reg[d];
            if (size_reg[d] == '0) begin
                zero_any = 1'b1;
            end
        end
    end

    for (genvar k = 0; k < NSTG; k++) begin : g_stage
        localparam int DK    = k / QW;
        localparam bit FIRST = (k % QW) == 0;
        localparam bit LAST  = (k % QW) == (QW - 1);
        l2s_ctrl_t     ctrl;
        logic [QW-1:0] a_in;
        logic [QW-1:0] r_in;

        if (k == 0) begin : g_head
            assign ctrl.valid = s_valid;
            assign a_in       = s_linear_index[QW-1:0];
            assign r_in       = '0;
            always_ff @(posedge aclk) begin
                if (en) begin
                    for (int d = 0; d < MAX_DIMS; d++) begin
                        sub_reg[k][d] <= '0;
                    end
                end
            end
        end else begin : g_body
            assign ctrl.valid = stg_valid[k-1];
            assign a_in       = stg_a[k-1];
            assign r_in       = FIRST ? '0 : stg_r[k-1];
            always_ff @(posedge aclk) begin
                if (en) begin
                    sub_reg[k] <= sub_src[k-1];
                end
            end
        end
        assign ctrl.en = en;

        l2s_div_step #(.QW(QW)) u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .in_a      (a_in),
            .in_r      (r_in),
            .divisor   (divisor[DK]),
            .out_valid (stg_valid[k]),
            .out_a     (stg_a[k]),
            .out_r     (stg_r[k])
        );

        always_comb begin
            for (int d = 0; d < MAX_DIMS; d++) begin
                sub_src[k][d] = (LAST && d == DK) ? stg_r[k] : sub_reg[k][d];
            end
        end
    end

    always_comb begin
        for (int d = 0; d < NUM_SIZE_REGS; d++) begin
            out_sub_next[d] = '0;
        end
        for (int d = 0; d < MAX_DIMS; d++) begin
            out_sub_next[d] = zero_any ? '0 : SUB_WIDTH'(sub_src[NSTG-1][d]);
        end
        out_oor_next = zero_any || (stg_a[NSTG-1] != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= stg_valid[NSTG-1];
        end
        if (en) begin
            out_sub_reg <= out_sub_next;
            out_oor_reg <= out_oor_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_sub0         = out_sub_reg[0];
    assign m_sub1         = out_sub_reg[1];
    assign m_sub2         = out_sub_reg[2];
    assign m_sub3         = out_sub_reg[3];
    assign m_sub4         = out_sub_reg[4];
    assign m_sub5         = out_sub_reg[5];
    assign m_out_of_range = out_oor_reg;

    a_zero_size_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && zero_any) |-> (m_out_of_range && m_sub0 == '0 && m_sub1 == '0))
        else $error("zero size must flag out of range and clear subscripts");

    a_sub0_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !zero_any) |-> (m_sub0 < size_reg[0]))
        else $error("sub0 not below size_dim0");

    a_sub1_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !zero_any) |-> (m_sub1 < size_reg[1]))
        else $error("sub1 not below size_dim1");

    a_stall_holds_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (stg_valid[NSTG-1] == $past(stg_valid[NSTG-1])))
        else $error("pipeline advanced during a stall");

endmodule

/* rtl/l2s_div_step.sv */
// One restoring division step: one quotient bit per stage.
module l2s_div_step import l2s_pkg::*; #(
    parameter int QW = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  l2s_ctrl_t     ctrl,
    input  logic [QW-1:0] in_a,
    input  logic [QW-1:0] in_r,
    input  size_t         divisor,
    output logic          out_valid,
    output logic [QW-1:0] out_a,
    output logic [QW-1:0] out_r
);

    logic [SIZE_WIDTH:0] trial;
    logic [SIZE_WIDTH:0] diff;
    logic                ge;
    logic                valid_reg;
    logic [QW-1:0]       a_reg;
    logic [QW-1:0]       r_reg;
    logic [QW-1:0]       a_next;
    logic [QW-1:0]       r_next;

    always_comb begin
        trial  = (SIZE_WIDTH+1)'({in_r, in_a[QW-1]});
        diff   = trial - {1'b0, divisor};
        ge     = trial >= {1'b0, divisor};
        r_next = ge ? diff[QW-1:0] : trial[QW-1:0];
        a_next = {in_a[QW-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctrl.en) begin
            valid_reg <= ctrl.valid;
        end
        if (ctrl.en) begin
            a_reg <= a_next;
            r_reg <= r_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_a     = a_reg;
    assign out_r     = r_reg;

endmodule
